// ===== hdl/lcs_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the lcs block
// no dependencies; used by lcs_ctrl, lcs_dp and lcs_length_and_traceback_unit
`default_nettype none

package lcs_pkg;

	localparam int MAX_LEN = 64;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int SYM_W   = 8;
	localparam int FUNC_W  = 2;
	localparam int ADDR_W  = 2 * IDX_W;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_FILL_DRAIN,
		ST_CHECK,
		ST_TB_RD,
		ST_TB_EV,
		ST_EM_RD,
		ST_EM_LD,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic load_first;
		logic load_second;
		logic fill_start;
		logic fill_issue;
		logic tb_start;
		logic tb_step;
		logic em_start;
		logic em_load;
		logic empty_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic seq_empty;
		logic fill_last;
		logic len_zero;
		logic tb_done;
		logic em_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lcs_ctrl.sv =====
// sequencing state machine: load, table fill, traceback, emit
// depends on lcs_pkg
`default_nettype none

module lcs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lcs_pkg::FUNC_W-1:0]    func,
	input  wire lcs_pkg::dp_status_t           status,
	output lcs_pkg::ctrl_cmd_t                 cmd
);

	lcs_pkg::state_t state_q;
	lcs_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = (state_q != lcs_pkg::ST_IDLE);
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (func)
						lcs_pkg::FUNC_LOAD_FIRST: begin
							cmd.load_first = 1'b1;
						end
						lcs_pkg::FUNC_LOAD_SECOND: begin
							cmd.load_second = 1'b1;
						end
						lcs_pkg::FUNC_COMPUTE: begin
							if (status.seq_empty) begin
								state_nxt = lcs_pkg::ST_EMPTY;
							end else begin
								cmd.fill_start = 1'b1;
								state_nxt      = lcs_pkg::ST_FILL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			lcs_pkg::ST_FILL: begin
				cmd.fill_issue = 1'b1;
				if (status.fill_last) begin
					state_nxt = lcs_pkg::ST_FILL_DRAIN;
				end
			end
			lcs_pkg::ST_FILL_DRAIN: begin
				// last cell is in the compute stage
				state_nxt = lcs_pkg::ST_CHECK;
			end
			lcs_pkg::ST_CHECK: begin
				if (status.len_zero) begin
					state_nxt = lcs_pkg::ST_EMPTY;
				end else begin
					cmd.tb_start = 1'b1;
					state_nxt    = lcs_pkg::ST_TB_RD;
				end
			end
			lcs_pkg::ST_TB_RD: begin
				if (status.tb_done) begin
					cmd.em_start = 1'b1;
					state_nxt    = lcs_pkg::ST_EM_RD;
				end else begin
					state_nxt = lcs_pkg::ST_TB_EV;
				end
			end
			lcs_pkg::ST_TB_EV: begin
				cmd.tb_step = 1'b1;
				state_nxt   = lcs_pkg::ST_TB_RD;
			end
			lcs_pkg::ST_EM_RD: begin
				state_nxt = lcs_pkg::ST_EM_LD;
			end
			lcs_pkg::ST_EM_LD: begin
				if (status.out_free) begin
					cmd.em_load = 1'b1;
					state_nxt   = status.em_last ? lcs_pkg::ST_IDLE : lcs_pkg::ST_EM_RD;
				end
			end
			lcs_pkg::ST_EMPTY: begin
				if (status.out_free) begin
					cmd.empty_load = 1'b1;
					state_nxt      = lcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lcs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/lcs_dp.sv =====
// datapath: sequence stores, length table, fill pipeline, traceback, result buffer, output
// depends on lcs_pkg; driven by lcs_ctrl commands
`default_nettype none

module lcs_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcs_pkg::ctrl_cmd_t            cmd,
	output lcs_pkg::dp_status_t                status,
	input  wire logic [lcs_pkg::SYM_W-1:0]     symbol,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lcs_pkg::SYM_W-1:0]          out_symbol,
	output logic [lcs_pkg::CNT_W-1:0]          subseq_len,
	output logic                               is_last,
	output logic                               is_empty,
	output logic                               overflowed
);

	localparam int IDX_W  = lcs_pkg::IDX_W;
	localparam int CNT_W  = lcs_pkg::CNT_W;
	localparam int SYM_W  = lcs_pkg::SYM_W;
	localparam int ADDR_W = lcs_pkg::ADDR_W;
	localparam int DEPTH  = lcs_pkg::MAX_LEN;

	logic [SYM_W-1:0] first_mem  [DEPTH];
	logic [SYM_W-1:0] second_mem [DEPTH];
	logic [SYM_W-1:0] result_mem [DEPTH];
	logic [CNT_W-1:0] length_mem [DEPTH*DEPTH];

	logic [CNT_W-1:0] first_cnt_q, second_cnt_q;
	logic             overflow_q;
	logic [IDX_W-1:0] row_q, col_q;
	logic             valid_s1, bypass_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic [CNT_W-1:0] last_v_q, diag_q;
	logic [SYM_W-1:0] a_rd_q, b_rd_q, res_rd_q;
	logic [CNT_W-1:0] up_rd_q, left_rd_q;
	logic [CNT_W-1:0] ti_q, tj_q, pos_q, len_q;
	logic [IDX_W-1:0] k_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_symbol_q;
	logic [CNT_W-1:0] subseq_len_q;
	logic             is_last_q, is_empty_q, overflowed_q;

	logic [CNT_W-1:0]  n_m1, m_m1, ti_m1, ti_m2, tj_m1, tj_m2, pos_m1, len_m1;
	logic [IDX_W-1:0]  row_m1, a_addr, b_addr;
	logic [ADDR_W-1:0] rd0_addr, rd1_addr;
	logic [CNT_W-1:0]  up_f, left_f, diag_f, cell_v;
	logic [CNT_W-1:0]  tb_up, tb_left;
	logic              first_full, second_full, tb_match, out_free;

	assign first_full  = (first_cnt_q == CNT_W'(DEPTH));
	assign second_full = (second_cnt_q == CNT_W'(DEPTH));
	assign n_m1   = first_cnt_q - CNT_W'(1);
	assign m_m1   = second_cnt_q - CNT_W'(1);
	assign ti_m1  = ti_q - CNT_W'(1);
	assign ti_m2  = ti_q - CNT_W'(2);
	assign tj_m1  = tj_q - CNT_W'(1);
	assign tj_m2  = tj_q - CNT_W'(2);
	assign pos_m1 = pos_q - CNT_W'(1);
	assign len_m1 = len_q - CNT_W'(1);
	assign row_m1 = row_q - IDX_W'(1);

	// fill reads row r of first, column c of second and the cell above; traceback reads
	// the cells above and to the left of (i, j)
	assign a_addr   = cmd.fill_issue ? row_q : ti_m1[IDX_W-1:0];
	assign b_addr   = cmd.fill_issue ? col_q : tj_m1[IDX_W-1:0];
	assign rd0_addr = cmd.fill_issue ? {row_m1, col_q} : {ti_m2[IDX_W-1:0], tj_m1[IDX_W-1:0]};
	assign rd1_addr = {ti_m1[IDX_W-1:0], tj_m2[IDX_W-1:0]};

	// fill compute stage; zero row and column are implicit
	always_comb begin
		up_f   = '0;
		left_f = '0;
		diag_f = '0;
		if (row_s1 != '0) begin
			up_f = bypass_s1 ? last_v_q : up_rd_q;
		end
		if (col_s1 != '0) begin
			left_f = last_v_q;
		end
		if (row_s1 != '0 && col_s1 != '0) begin
			diag_f = diag_q;
		end
		if (a_rd_q == b_rd_q) begin
			cell_v = diag_f + CNT_W'(1);
		end else begin
			cell_v = (up_f > left_f) ? up_f : left_f;
		end
	end

	assign tb_up    = (ti_q == CNT_W'(1)) ? '0 : up_rd_q;
	assign tb_left  = (tj_q == CNT_W'(1)) ? '0 : left_rd_q;
	assign tb_match = (a_rd_q == b_rd_q);
	assign out_free = !out_valid_q || !out_stall;

	assign status.seq_empty = (first_cnt_q == '0) || (second_cnt_q == '0);
	assign status.fill_last = (row_q == n_m1[IDX_W-1:0]) && (col_q == m_m1[IDX_W-1:0]);
	assign status.len_zero  = (last_v_q == '0);
	assign status.tb_done   = (ti_q == '0) || (tj_q == '0);
	assign status.em_last   = (CNT_W'(k_q) == len_m1);
	assign status.out_free  = out_free;

	// sequence stores
	always_ff @(posedge clk) begin
		if (cmd.load_first && !first_full) begin
			first_mem[first_cnt_q[IDX_W-1:0]] <= symbol;
		end
		if (cmd.load_second && !second_full) begin
			second_mem[second_cnt_q[IDX_W-1:0]] <= symbol;
		end
		a_rd_q <= first_mem[a_addr];
		b_rd_q <= second_mem[b_addr];
	end

	// length table: one write port, two read ports
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			length_mem[{row_s1, col_s1}] <= cell_v;
		end
		up_rd_q   <= length_mem[rd0_addr];
		left_rd_q <= length_mem[rd1_addr];
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (cmd.tb_step && tb_match && pos_q != '0) begin
			result_mem[pos_m1[IDX_W-1:0]] <= a_rd_q;
		end
		res_rd_q <= result_mem[k_q];
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		col_s1 <= col_q;
		if (valid_s1) begin
			last_v_q <= cell_v;
			diag_q   <= up_f;
		end
		if (cmd.em_load) begin
			out_symbol_q <= res_rd_q;
			subseq_len_q <= len_q;
			is_last_q    <= status.em_last;
			is_empty_q   <= 1'b0;
			overflowed_q <= overflow_q;
		end else if (cmd.empty_load) begin
			out_symbol_q <= '0;
			subseq_len_q <= '0;
			is_last_q    <= 1'b1;
			is_empty_q   <= 1'b1;
			overflowed_q <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			overflow_q   <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			valid_s1     <= 1'b0;
			bypass_s1    <= 1'b0;
			ti_q         <= '0;
			tj_q         <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_first) begin
				if (first_full) begin
					overflow_q <= 1'b1;
				end else begin
					first_cnt_q <= first_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.load_second) begin
				if (second_full) begin
					overflow_q <= 1'b1;
				end else begin
					second_cnt_q <= second_cnt_q + CNT_W'(1);
				end
			end

			if (cmd.fill_start) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.fill_issue) begin
				if (col_q == m_m1[IDX_W-1:0]) begin
					col_q <= '0;
					row_q <= row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
			valid_s1 <= cmd.fill_issue;
			// one-column table: the cell above is still in the compute stage
			bypass_s1 <= cmd.fill_issue && valid_s1 && (row_m1 == row_s1) && (col_q == col_s1);

			if (cmd.tb_start) begin
				ti_q  <= first_cnt_q;
				tj_q  <= second_cnt_q;
				pos_q <= last_v_q;
				len_q <= last_v_q;
			end else if (cmd.tb_step) begin
				if (tb_match) begin
					if (pos_q != '0) begin
						pos_q <= pos_m1;
					end
					ti_q <= ti_m1;
					tj_q <= tj_m1;
				end else if (tb_up > tb_left) begin
					ti_q <= ti_m1;
				end else begin
					tj_q <= tj_m1;
				end
			end

			if (cmd.em_start) begin
				k_q <= '0;
			end else if (cmd.em_load) begin
				k_q <= k_q + IDX_W'(1);
			end

			if (cmd.em_load || cmd.empty_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign subseq_len = subseq_len_q;
	assign is_last    = is_last_q;
	assign is_empty   = is_empty_q;
	assign overflowed = overflowed_q;

endmodule

`default_nettype wire

// ===== hdl/lcs_length_and_traceback_unit.sv =====
// top level of the longest common subsequence unit: controller plus datapath
// depends on lcs_pkg, lcs_ctrl and lcs_dp
//
//   channel | handshake           | fields
//   --------+---------------------+-------------------------------------------------
//   in      | in_valid/in_stall   | func, symbol
//   out     | out_valid/out_stall | out_symbol, subseq_len, is_last, is_empty, overflowed
//
// a compute with sequence lengths n, m and result length L makes s traceback steps
// (s <= n+m-1) and emits L results: the table fill retires one cell per cycle through
// the single write port of the length table, each traceback step takes a read and an
// evaluate state, and each result a buffer read and a load state, the load waiting
// while the output is stalled.
// reset clears counts, overflow flag and control; the stores need no clearing.
// a stalled output holds the emit sequence; loads are taken while the last result waits.
`default_nettype none

module lcs_length_and_traceback_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [lcs_pkg::FUNC_W-1:0]        func,
	input  wire logic [lcs_pkg::SYM_W-1:0]         symbol,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [lcs_pkg::SYM_W-1:0]              out_symbol,
	output logic [lcs_pkg::CNT_W-1:0]              subseq_len,
	output logic                                   is_last,
	output logic                                   is_empty,
	output logic                                   overflowed
);

	lcs_pkg::ctrl_cmd_t  cmd;
	lcs_pkg::dp_status_t status;

	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.status   (status),
		.cmd      (cmd)
	);

	lcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_symbol (out_symbol),
		.subseq_len (subseq_len),
		.is_last    (is_last),
		.is_empty   (is_empty),
		.overflowed (overflowed)
	);

endmodule

`default_nettype wire
